>>> src/pcx_rle_decoder_core_defines.svh
// Assertion macros for the PCX run-length decoder.
// Included by the top level; needs nothing else.
`ifndef PCX_RLE_DECODER_CORE_DEFINES_SVH
`define PCX_RLE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PCXRLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define PCXRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pcxrle_pkg.sv
// Shared types and constants for the PCX run-length decoder.
// No dependencies.
package pcxrle_pkg;

    localparam int VALUE_W = 8;
    localparam int COUNT_W = 6;
    localparam int SIZE_W  = 24;

    // Run header: both top bits set; low six bits hold the repeat count
    localparam logic [VALUE_W-1:0] RUN_MASK   = 8'hC0;
    localparam logic [VALUE_W-1:0] COUNT_MASK = 8'h3F;

    // One emit command handed from the front to the back
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic               done;
    } cmd_t;

endpackage

>>> src/pcxrle_front.sv
// Front end: holds the size register, classifies encoded bytes and
// issues truncated emit commands. Depends on pcxrle_pkg.
module pcxrle_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pcxrle_pkg::SIZE_W-1:0]      cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [pcxrle_pkg::VALUE_W-1:0]     in_byte,
    input  logic                               q_full,
    output logic                               push,
    output pcxrle_pkg::cmd_t                   push_cmd
);

    logic [pcxrle_pkg::SIZE_W-1:0]  expected_reg;
    logic [pcxrle_pkg::SIZE_W-1:0]  committed_reg, committed_next;
    logic                           awaiting_reg, awaiting_next;
    logic [pcxrle_pkg::COUNT_W-1:0] run_count_reg, run_count_next;

    logic                           accepted;
    logic                           complete;
    logic                           is_header;
    logic [pcxrle_pkg::SIZE_W-1:0]  remaining;
    logic [pcxrle_pkg::COUNT_W-1:0] raw_count;
    logic [pcxrle_pkg::COUNT_W-1:0] eff_count;
    logic                           emits;

    assign in_stall = q_full;
    assign accepted = in_valid && !in_stall;

    // Classify the request against the bytes already committed
    assign complete  = committed_reg >= expected_reg;
    assign remaining = expected_reg - committed_reg;
    assign is_header = !awaiting_reg &&
                       ((in_byte & pcxrle_pkg::RUN_MASK) == pcxrle_pkg::RUN_MASK);
    assign raw_count = awaiting_reg ? run_count_reg
                                    : pcxrle_pkg::COUNT_W'(1);

    // Truncate a run that would overshoot the image
    assign eff_count = (remaining < pcxrle_pkg::SIZE_W'(raw_count))
                       ? remaining[pcxrle_pkg::COUNT_W-1:0] : raw_count;
    assign emits     = accepted && !complete && !is_header;

    assign push           = emits && (eff_count != '0);
    assign push_cmd.value = in_byte;
    assign push_cmd.count = eff_count;
    assign push_cmd.done  = (pcxrle_pkg::SIZE_W'(eff_count) == remaining);

    // Advance the decode state
    always_comb
    begin
        awaiting_next  = awaiting_reg;
        run_count_next = run_count_reg;
        committed_next = committed_reg;
        if (accepted && !complete)
        begin
            if (is_header)
            begin
                awaiting_next  = 1'b1;
                run_count_next = pcxrle_pkg::COUNT_W'(in_byte & pcxrle_pkg::COUNT_MASK);
            end
            else
            begin
                awaiting_next  = 1'b0;
                run_count_next = '0;
                committed_next = committed_reg + pcxrle_pkg::SIZE_W'(eff_count);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg  <= '0;
            committed_reg <= '0;
            awaiting_reg  <= 1'b0;
            run_count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                expected_reg <= cfg_data;
            end
            committed_reg <= committed_next;
            awaiting_reg  <= awaiting_next;
            run_count_reg <= run_count_next;
        end
    end

endmodule

>>> src/pcxrle_queue.sv
// Short command queue between the front and back ends.
// Depends on pcxrle_pkg for the command type.
module pcxrle_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pcxrle_pkg::cmd_t push_cmd,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output pcxrle_pkg::cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pcxrle_pkg::cmd_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] level_reg, level_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (level_reg == CNT_W'(DEPTH));
    assign empty    = (level_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = entries_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> src/pcxrle_back.sv
// Back end: expands queued commands into decoded bytes behind an
// output register. Depends on pcxrle_pkg.
module pcxrle_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  pcxrle_pkg::cmd_t               head_cmd,
    output logic                           pop,
    output logic                           busy,
    output logic [pcxrle_pkg::COUNT_W-1:0] left,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pcxrle_pkg::VALUE_W-1:0] pixel_byte,
    output logic                           run_last,
    output logic                           image_done
);

    logic                           busy_reg;
    logic [pcxrle_pkg::VALUE_W-1:0] value_reg;
    logic [pcxrle_pkg::COUNT_W-1:0] left_reg;
    logic                           done_reg;

    logic                           out_valid_reg;
    logic [pcxrle_pkg::VALUE_W-1:0] pixel_reg;
    logic                           last_reg;
    logic                           image_done_reg;

    logic                           slot_free;
    logic                           emit;
    logic                           final_byte;

    assign slot_free  = !out_valid_reg || !out_stall;
    assign emit       = busy_reg && slot_free;
    assign final_byte = (left_reg == pcxrle_pkg::COUNT_W'(1));
    assign pop        = !q_empty && (!busy_reg || (emit && final_byte));

    assign busy       = busy_reg;
    assign left       = left_reg;
    assign out_valid  = out_valid_reg;
    assign pixel_byte = pixel_reg;
    assign run_last   = last_reg;
    assign image_done = image_done_reg;

    // Load a new command or count down the current one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            left_reg <= '0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            left_reg <= head_cmd.count;
        end
        else if (emit)
        begin
            busy_reg <= !final_byte;
            left_reg <= left_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            value_reg <= head_cmd.value;
            done_reg  <= head_cmd.done;
        end
    end

    // Hold the output request until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pixel_reg      <= value_reg;
            last_reg       <= final_byte;
            image_done_reg <= done_reg && final_byte;
        end
    end

endmodule

>>> src/pcx_rle_decoder_core.sv
// Channel   | valid     | stall     | payload
// ----------+-----------+-----------+----------------------------------
// input     | in_valid  | in_stall  | in_byte
// output    | out_valid | out_stall | pixel_byte, run_last, image_done
// config    | cfg_we    | (none)    | cfg_data
//
// A literal emits one byte and a run emits its repeat count of bytes;
// a run header consumes an input byte and queues no command.
// Throughput is set by the back end, which emits one byte per cycle while it has a command and out_stall is low.
// Input is stalled only while the command queue is full.
// Reset clears all control state; the image size resets to zero.
// Top level of the PCX run-length decoder; uses pcxrle_pkg,
// pcxrle_front, pcxrle_queue, pcxrle_back and the assertion macros.
`include "pcx_rle_decoder_core_defines.svh"

module pcx_rle_decoder_core
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pcxrle_pkg::SIZE_W-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [pcxrle_pkg::VALUE_W-1:0] in_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pcxrle_pkg::VALUE_W-1:0] pixel_byte,
    output logic                           run_last,
    output logic                           image_done
);

    logic                           q_full;
    logic                           q_empty;
    logic                           push;
    logic                           pop;
    pcxrle_pkg::cmd_t               push_cmd;
    pcxrle_pkg::cmd_t               head_cmd;
    logic                           busy;
    logic [pcxrle_pkg::COUNT_W-1:0] left;

    pcxrle_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    pcxrle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head_cmd (head_cmd)
    );

    pcxrle_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .busy       (busy),
        .left       (left),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_byte (pixel_byte),
        .run_last   (run_last),
        .image_done (image_done)
    );

    // Checks on the decoder's own logic
    `PCXRLE_ASSERT_NOW(a_push_nonzero, clk, rst_n, push, push_cmd.count != '0, "empty command queued")
    `PCXRLE_ASSERT_NOW(a_busy_left, clk, rst_n, busy, left != '0, "back end busy with no bytes left")
    `PCXRLE_ASSERT_NOW(a_done_last, clk, rst_n, out_valid && image_done, run_last, "image done off a run end")
    `PCXRLE_ASSERT_NEXT(a_pop_busy, clk, rst_n, pop, busy, "command popped but back end idle")

endmodule
